FILE: rtl/sdsr_pkg.sv
// ============================================================================
// sdsr_pkg
// Shared types, constants and the segment font of the screen rotator.
// ============================================================================
package sdsr_pkg;

  // Number of screens held in the store
  localparam int SCREENS = 3;
  // Bits of a stored screen index
  localparam int SW      = (SCREENS > 1) ? $clog2(SCREENS) : 1;
  // Wide enough to compare any index against SCREENS
  localparam int CMP_W   = 4;

  localparam int HALF_W    = 16;
  localparam int CHAR_W    = 8;
  localparam int DWELL_W   = 8;
  localparam int IDX_W     = 2;
  localparam int NUM_REGS  = 3;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DWELL0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DWELL1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DWELL2 = 2'd2;

  localparam logic [DWELL_W-1:0] DWELL0_RST   = 8'd2;
  localparam logic [DWELL_W-1:0] DWELL1_RST   = 8'd2;
  localparam logic [DWELL_W-1:0] DWELL2_RST   = 8'd1;
  // Dwell of a screen that has no register of its own
  localparam logic [DWELL_W-1:0] DWELL_OTHER  = 8'd1;

  // Comma bits of each half
  localparam logic [HALF_W-1:0] COMMA_FIRST  = 16'h0080;
  localparam logic [HALF_W-1:0] COMMA_SECOND = 16'h0001;

  // Digit range of the font
  localparam logic [CHAR_W-1:0] DIGIT_LO = 8'd48;
  localparam logic [CHAR_W-1:0] DIGIT_HI = 8'd58;

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_RAW  = 2'd1,
    REQ_TEXT = 2'd2,
    REQ_OFF  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_TEXT,
    ST_WRITE
  } state_e;

  typedef logic [NUM_REGS-1:0][DWELL_W-1:0] dwell_t;

  // Store write request
  typedef struct packed {
    logic                  en;
    logic [SW-1:0]         addr;
    logic [2*HALF_W-1:0]   data;
  } store_wr_t;

  // Screen handed to the output register
  typedef struct packed {
    logic                valid;
    logic [HALF_W-1:0]   left;
    logic [HALF_W-1:0]   right;
    logic [IDX_W-1:0]    shown;
  } emit_t;

  typedef struct packed {
    logic              hit;
    logic [HALF_W-1:0] a;
    logic [HALF_W-1:0] b;
  } glyph_t;

  localparam logic [9:0][HALF_W-1:0] DIGIT_A = {
    16'h0F50, 16'h0F70, 16'h0A40, 16'h0770, 16'h0750,
    16'h0D40, 16'h0B50, 16'h0B30, 16'h0840, 16'h0E70
  };
  localparam logic [9:0][HALF_W-1:0] DIGIT_B = {
    16'hF00A, 16'hF00E, 16'h5002, 16'hE00E, 16'hE00A,
    16'hB002, 16'hD00A, 16'hD00C, 16'h1002, 16'h700E
  };

  // Font lookup: pattern pair of a character, hit clear where none exists
  function automatic glyph_t glyph(input logic [CHAR_W-1:0] c);
    glyph_t        g;
    logic [CHAR_W-1:0] off;
    off = c - DIGIT_LO;
    g   = '{hit: 1'b1, a: '0, b: '0};
    if (c >= DIGIT_LO && c < DIGIT_HI) begin
      g.a = DIGIT_A[off[3:0]];
      g.b = DIGIT_B[off[3:0]];
    end else begin
      case (c)
        8'h2D: begin g.a = 16'h0100; g.b = 16'h8000; end // '-'
        8'h20: begin g.a = 16'h0000; g.b = 16'h0000; end // ' '
        8'h41: begin g.a = 16'h0FE0; g.b = 16'hF006; end // 'A'
        8'h43: begin g.a = 16'h0630; g.b = 16'h600C; end // 'C'
        8'h45: begin g.a = 16'h0730; g.b = 16'hE00C; end // 'E'
        8'h46: begin g.a = 16'h0720; g.b = 16'hE004; end // 'F'
        8'h48: begin g.a = 16'h0D60; g.b = 16'hB006; end // 'H'
        8'h49: begin g.a = 16'h0840; g.b = 16'h1002; end // 'I'
        8'h4A: begin g.a = 16'h0850; g.b = 16'h100A; end // 'J'
        8'h4C: begin g.a = 16'h0430; g.b = 16'h200C; end // 'L'
        8'h50: begin g.a = 16'h0F20; g.b = 16'hF004; end // 'P'
        8'h55: begin g.a = 16'h0C70; g.b = 16'h300E; end // 'U'
        8'h62: begin g.a = 16'h0570; g.b = 16'hA00E; end // 'b'
        8'h63: begin g.a = 16'h0130; g.b = 16'h800C; end // 'c'
        8'h64: begin g.a = 16'h0970; g.b = 16'h900E; end // 'd'
        8'h68: begin g.a = 16'h0560; g.b = 16'hA006; end // 'h'
        8'h69: begin g.a = 16'h0040; g.b = 16'h0002; end // 'i'
        8'h6C: begin g.a = 16'h0420; g.b = 16'h2004; end // 'l'
        8'h6E: begin g.a = 16'h0160; g.b = 16'h8006; end // 'n'
        8'h6F: begin g.a = 16'h0170; g.b = 16'h800E; end // 'o'
        8'h75: begin g.a = 16'h0070; g.b = 16'h000E; end // 'u'
        default: g.hit = 1'b0;
      endcase
    end
    return g;
  endfunction

endpackage

FILE: rtl/sdsr_if.sv
// ============================================================================
// sdsr_if
// Valid/ready channels of the screen rotator: request items and screens.
// ============================================================================
interface sdsr_in_if;
  import sdsr_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [IDX_W-1:0]  screen_index;
  logic [HALF_W-1:0] left_value;
  logic [HALF_W-1:0] right_value;
  logic [CHAR_W-1:0] char_0;
  logic [CHAR_W-1:0] char_1;
  logic [CHAR_W-1:0] char_2;
  logic [CHAR_W-1:0] char_3;
  logic [3:0]        comma_mask;

  modport source (
    output valid, req_type, screen_index, left_value, right_value,
           char_0, char_1, char_2, char_3, comma_mask,
    input  ready
  );
  modport sink (
    input  valid, req_type, screen_index, left_value, right_value,
           char_0, char_1, char_2, char_3, comma_mask,
    output ready
  );
endinterface

interface sdsr_out_if;
  import sdsr_pkg::*;
  logic              valid;
  logic              ready;
  logic [HALF_W-1:0] left_segments;
  logic [HALF_W-1:0] right_segments;
  logic [IDX_W-1:0]  shown_screen;

  modport source (
    output valid, left_segments, right_segments, shown_screen,
    input  ready
  );
  modport sink (
    input  valid, left_segments, right_segments, shown_screen,
    output ready
  );
endinterface

FILE: rtl/sdsr_store.sv
// ============================================================================
// sdsr_store
// Screen register file: one write port, one read port, empty flags.
// ============================================================================
module sdsr_store (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sdsr_pkg::store_wr_t               wr_i,
  input  logic [sdsr_pkg::SW-1:0]           rd_addr_i,
  output logic [2*sdsr_pkg::HALF_W-1:0]     rd_data_o,
  output logic                              any_o
);
  import sdsr_pkg::*;

  logic [SCREENS-1:0][2*HALF_W-1:0] screens_q;
  logic [SCREENS-1:0]               nz;

  // Write one screen
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screens_q <= '0;
    end else if (wr_i.en) begin
      screens_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Flag screens that hold anything
  always_comb begin
    for (int s = 0; s < SCREENS; s++) begin
      nz[s] = |screens_q[s];
    end
  end

  assign any_o = |nz;

  // Read; an address past the last screen reads as empty
  assign rd_data_o = (CMP_W'(rd_addr_i) < CMP_W'(SCREENS)) ? screens_q[rd_addr_i] : '0;

endmodule

FILE: rtl/sdsr_ctrl.sv
// ============================================================================
// sdsr_ctrl
// Sequencer of the rotator: screen scan, dwell count and text encoding.
// ============================================================================
module sdsr_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sdsr_pkg::dwell_t              dwell_i,
  // Request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    in_req_i,
  input  logic [sdsr_pkg::IDX_W-1:0]    in_idx_i,
  input  logic [sdsr_pkg::HALF_W-1:0]   in_left_i,
  input  logic [sdsr_pkg::HALF_W-1:0]   in_right_i,
  input  logic [3:0][sdsr_pkg::CHAR_W-1:0] in_chars_i,
  input  logic [3:0]                    in_comma_i,
  // Store
  output sdsr_pkg::store_wr_t           wr_o,
  output logic [sdsr_pkg::SW-1:0]       rd_addr_o,
  input  logic [2*sdsr_pkg::HALF_W-1:0] rd_data_i,
  input  logic                          any_i,
  // Output register
  input  logic                          slot_free_i,
  output sdsr_pkg::emit_t               emit_o
);
  import sdsr_pkg::*;

  state_e                    state_q, state_d;
  logic [SW-1:0]             cur_q, cur_d;
  logic [DWELL_W-1:0]        cnt_q, cnt_d;
  logic [SW-1:0]             idx_q, idx_d;
  logic [3:0][CHAR_W-1:0]    chars_q, chars_d;
  logic [3:0]                comma_q, comma_d;
  logic [HALF_W-1:0]         left_q, left_d;
  logic [HALF_W-1:0]         right_q, right_d;
  logic [1:0]                pos_q, pos_d;

  logic                      accept;
  logic                      in_range;
  logic                      cur_nz;
  logic [SW-1:0]             cur_next;
  logic [DWELL_W-1:0]        cnt_inc;
  logic [DWELL_W-1:0]        dwell_cur;
  logic [CHAR_W-1:0]         ch;
  glyph_t                    g;
  logic [HALF_W-1:0]         left_fin;
  logic [HALF_W-1:0]         right_fin;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign in_range   = CMP_W'(in_idx_i) < CMP_W'(SCREENS);
  assign cur_nz     = |rd_data_i;
  assign cur_next   = (cur_q == SW'(SCREENS - 1)) ? '0 : cur_q + SW'(1);
  assign cnt_inc    = cnt_q + DWELL_W'(1);

  // Dwell of the current screen
  always_comb begin
    if (CMP_W'(cur_q) == CMP_W'(REG_DWELL0)) begin
      dwell_cur = dwell_i[REG_DWELL0];
    end else if (CMP_W'(cur_q) == CMP_W'(REG_DWELL1)) begin
      dwell_cur = dwell_i[REG_DWELL1];
    end else if (CMP_W'(cur_q) == CMP_W'(REG_DWELL2)) begin
      dwell_cur = dwell_i[REG_DWELL2];
    end else begin
      dwell_cur = DWELL_OTHER;
    end
  end

  // Font unit, one character a cycle
  assign ch = chars_q[pos_q];
  assign g  = glyph(ch);

  // Commas go in as the screen is written back
  assign left_fin  = left_q  | (comma_q[0] ? COMMA_FIRST  : '0)
                             | (comma_q[1] ? COMMA_SECOND : '0);
  assign right_fin = right_q | (comma_q[2] ? COMMA_FIRST  : '0)
                             | (comma_q[3] ? COMMA_SECOND : '0);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_req_i == REQ_TICK) begin
            state_d = any_i ? ST_SCAN : ST_IDLE;
          end else if (!in_range) begin
            state_d = ST_IDLE;
          end else if (in_req_i == REQ_TEXT) begin
            state_d = ST_TEXT;
          end else begin
            state_d = ST_WRITE;
          end
        end
      end
      ST_SCAN:  if (cur_nz) state_d = ST_EMIT;
      ST_EMIT:  if (slot_free_i) state_d = ST_IDLE;
      ST_TEXT:  if (pos_q == 2'd3) state_d = ST_WRITE;
      ST_WRITE: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs to store and output register
  always_comb begin
    rd_addr_o = cur_q;
    wr_o      = '{en: 1'b0, addr: idx_q, data: {left_fin, right_fin}};
    emit_o    = '{valid: 1'b0, left: rd_data_i[2*HALF_W-1:HALF_W],
                  right: rd_data_i[HALF_W-1:0], shown: IDX_W'(cur_q)};
    case (state_q)
      ST_IDLE:  rd_addr_o    = SW'(in_idx_i);
      ST_EMIT:  emit_o.valid = slot_free_i;
      ST_WRITE: wr_o.en      = 1'b1;
      default: ;
    endcase
  end

  // Datapath registers
  always_comb begin
    cur_d   = cur_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    chars_d = chars_q;
    comma_d = comma_q;
    left_d  = left_q;
    right_d = right_q;
    pos_d   = pos_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_d   = SW'(in_idx_i);
          chars_d = in_chars_i;
          pos_d   = '0;
          case (in_req_i)
            REQ_RAW: begin
              left_d  = in_left_i;
              right_d = in_right_i;
              comma_d = '0;
            end
            REQ_TEXT: begin
              left_d  = rd_data_i[2*HALF_W-1:HALF_W];
              right_d = rd_data_i[HALF_W-1:0];
              comma_d = in_comma_i;
            end
            default: begin
              left_d  = '0;
              right_d = '0;
              comma_d = '0;
            end
          endcase
        end
      end
      // Skip empty screens
      ST_SCAN: if (!cur_nz) cur_d = cur_next;
      // Count dwell, advance once it is used up
      ST_EMIT: begin
        if (slot_free_i) begin
          if (cnt_inc >= dwell_cur) begin
            cnt_d = '0;
            cur_d = cur_next;
          end else begin
            cnt_d = cnt_inc;
          end
        end
      end
      // Encode one character position
      ST_TEXT: begin
        if (ch != '0 && g.hit) begin
          case (pos_q)
            2'd0:    left_d  = g.a;
            2'd1:    left_d  = left_q | g.b;
            2'd2:    right_d = g.a;
            default: right_d = right_q | g.b;
          endcase
        end
        pos_d = pos_q + 2'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cur_q   <= '0;
      cnt_q   <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
    end
  end

  // Request payload, no reset needed
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    chars_q <= chars_d;
    comma_q <= comma_d;
    left_q  <= left_d;
    right_q <= right_d;
  end

endmodule

FILE: rtl/segment_display_screen_rotator_top.sv
// ============================================================================
// segment_display_screen_rotator_top
// Carousel of segment screens with dwell counting and text encoding.
// ============================================================================
//
//  channel   dir  handshake            payload
//  in_i      in   valid / ready        request item (type, index, values, text)
//  out_o     out  valid / ready        shown screen (left, right, index)
//  cfg       in   cfg_we_i, no ready   dwell registers by index
//
//  Tick: skips empty screens (at most SCREENS - 1) and waits for the output
//  register to drain if it is full. Text write: the font unit encodes one
//  character per cycle. in_i is ready only when idle; a finished screen
//  waits in the output register while the next item runs.
//  Reset empties the store and loads the dwell registers with 2, 2, 1.
//
module segment_display_screen_rotator_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sdsr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sdsr_pkg::DWELL_W-1:0]      cfg_data_i,
  sdsr_in_if.sink                           in_i,
  sdsr_out_if.source                        out_o
);
  import sdsr_pkg::*;

  dwell_t                   dwell_q;
  store_wr_t                wr;
  logic [SW-1:0]            rd_addr;
  logic [2*HALF_W-1:0]      rd_data;
  logic                     any;
  emit_t                    emit;
  logic                     slot_free;
  logic                     out_valid_q;
  logic [HALF_W-1:0]        out_left_q;
  logic [HALF_W-1:0]        out_right_q;
  logic [IDX_W-1:0]         out_shown_q;

  // Dwell registers; writes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_q[REG_DWELL0] <= DWELL0_RST;
      dwell_q[REG_DWELL1] <= DWELL1_RST;
      dwell_q[REG_DWELL2] <= DWELL2_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DWELL0: dwell_q[REG_DWELL0] <= cfg_data_i;
        REG_DWELL1: dwell_q[REG_DWELL1] <= cfg_data_i;
        REG_DWELL2: dwell_q[REG_DWELL2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sdsr_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .any_o     (any)
  );

  sdsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dwell_i     (dwell_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_req_i    (in_i.req_type),
    .in_idx_i    (in_i.screen_index),
    .in_left_i   (in_i.left_value),
    .in_right_i  (in_i.right_value),
    .in_chars_i  ({in_i.char_3, in_i.char_2, in_i.char_1, in_i.char_0}),
    .in_comma_i  (in_i.comma_mask),
    .wr_o        (wr),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .any_i       (any),
    .slot_free_i (slot_free),
    .emit_o      (emit)
  );

  // Output register: load on emit, drop once taken
  assign slot_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_left_q  <= emit.left;
      out_right_q <= emit.right;
      out_shown_q <= emit.shown;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.left_segments  = out_left_q;
  assign out_o.right_segments = out_right_q;
  assign out_o.shown_screen   = out_shown_q;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the segment screen rotator: a mirror of the store,
// dwell counter and font predicts every shown screen, random gaps and a long
// output hold-off exercise both handshakes across several dwell settings.
// ============================================================================
module tb_top;
  import sdsr_pkg::*;

  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int END_WAIT     = 20000;

  // Every character the font knows, in one packed string
  localparam int          FONT_N   = 31;
  localparam logic [FONT_N*8-1:0] FONT_SET = "0123456789- ACEFHIJLPUbcdhilnou";

  // Digit patterns, digit zero first
  localparam logic [10*HALF_W-1:0] DIG_LEFT = {
    16'h0E70, 16'h0840, 16'h0B30, 16'h0B50, 16'h0D40,
    16'h0750, 16'h0770, 16'h0A40, 16'h0F70, 16'h0F50
  };
  localparam logic [10*HALF_W-1:0] DIG_RIGHT = {
    16'h700E, 16'h1002, 16'hD00C, 16'hD00A, 16'hB002,
    16'hE00A, 16'hE00E, 16'h5002, 16'hF00E, 16'hF00A
  };

  typedef struct packed {
    req_e                    kind;
    logic [IDX_W-1:0]        idx;
    logic [HALF_W-1:0]       lv;
    logic [HALF_W-1:0]       rv;
    logic [0:3][CHAR_W-1:0]  chars;
    logic [3:0]              commas;
  } request_t;

  typedef struct packed {
    logic [HALF_W-1:0] left;
    logic [HALF_W-1:0] right;
    logic [IDX_W-1:0]  shown;
  } screen_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DWELL_W-1:0]   cfg_data_i;

  sdsr_in_if  req_if ();
  sdsr_out_if scr_if ();

  segment_display_screen_rotator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (req_if),
    .out_o       (scr_if)
  );

  // Mirror of the block state
  logic [2*HALF_W-1:0] mirror_store [SCREENS];
  logic [DWELL_W-1:0]  mirror_count;
  logic [IDX_W-1:0]    mirror_cur;
  logic [DWELL_W-1:0]  mirror_dwell [NUM_REGS];

  screen_t screens_due [$];

  int  mismatches     = 0;
  int  n_items        = 0;
  int  n_checked      = 0;
  int  n_empty_ticks  = 0;
  int  n_ignored      = 0;
  int  n_settings     = 0;
  bit  src_gaps       = 1'b1;
  logic sink_gaps;
  logic hold_out;

  always #2 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic logic font_pair(input logic [CHAR_W-1:0] c,
                                     output logic [HALF_W-1:0] a,
                                     output logic [HALF_W-1:0] b);
    int d;
    a = '0;
    b = '0;
    if (c >= 8'd48 && c < 8'd58) begin
      d = int'(c) - 48;
      a = DIG_LEFT[HALF_W*(9-d) +: HALF_W];
      b = DIG_RIGHT[HALF_W*(9-d) +: HALF_W];
      return 1'b1;
    end
    case (c)
      "-": begin a = 16'h0100; b = 16'h8000; end
      " ": begin a = 16'h0000; b = 16'h0000; end
      "A": begin a = 16'h0FE0; b = 16'hF006; end
      "C": begin a = 16'h0630; b = 16'h600C; end
      "E": begin a = 16'h0730; b = 16'hE00C; end
      "F": begin a = 16'h0720; b = 16'hE004; end
      "H": begin a = 16'h0D60; b = 16'hB006; end
      "I": begin a = 16'h0840; b = 16'h1002; end
      "J": begin a = 16'h0850; b = 16'h100A; end
      "L": begin a = 16'h0430; b = 16'h200C; end
      "P": begin a = 16'h0F20; b = 16'hF004; end
      "U": begin a = 16'h0C70; b = 16'h300E; end
      "b": begin a = 16'h0570; b = 16'hA00E; end
      "c": begin a = 16'h0130; b = 16'h800C; end
      "d": begin a = 16'h0970; b = 16'h900E; end
      "h": begin a = 16'h0560; b = 16'hA006; end
      "i": begin a = 16'h0040; b = 16'h0002; end
      "l": begin a = 16'h0420; b = 16'h2004; end
      "n": begin a = 16'h0160; b = 16'h8006; end
      "o": begin a = 16'h0170; b = 16'h800E; end
      "u": begin a = 16'h0070; b = 16'h000E; end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] s);
    return (int'(s) + 1 >= SCREENS) ? '0 : IDX_W'(int'(s) + 1);
  endfunction

  function automatic logic [DWELL_W-1:0] dwell_for(input logic [IDX_W-1:0] s);
    return (int'(s) < NUM_REGS) ? mirror_dwell[s] : DWELL_OTHER;
  endfunction

  // Update the mirror with one accepted item; queue the screen a tick shows
  task automatic apply_request(input request_t r);
    logic              any;
    logic              hit;
    logic [IDX_W-1:0]  cur;
    logic [HALF_W-1:0] l, rt, a, b;
    screen_t           s;
    any = 1'b0;
    for (int i = 0; i < SCREENS; i++) any |= (mirror_store[i] != '0);
    if (r.kind == REQ_TICK) begin
      if (!any) begin
        n_empty_ticks++;
        return;
      end
      cur = mirror_cur;
      if (int'(cur) >= SCREENS) cur = '0;
      while (mirror_store[cur] == '0) cur = next_index(cur);
      s.left  = mirror_store[cur][2*HALF_W-1:HALF_W];
      s.right = mirror_store[cur][HALF_W-1:0];
      s.shown = cur;
      screens_due.push_back(s);
      mirror_count = mirror_count + 1'b1;
      if (mirror_count >= dwell_for(cur)) begin
        mirror_count = '0;
        cur = next_index(cur);
      end
      mirror_cur = cur;
      return;
    end
    if (int'(r.idx) >= SCREENS) begin
      n_ignored++;
      return;
    end
    case (r.kind)
      REQ_RAW: mirror_store[r.idx] = {r.lv, r.rv};
      REQ_TEXT: begin
        l  = mirror_store[r.idx][2*HALF_W-1:HALF_W];
        rt = mirror_store[r.idx][HALF_W-1:0];
        for (int p = 0; p < 4; p++) begin
          if (r.chars[p] == '0) continue;
          hit = font_pair(r.chars[p], a, b);
          if (!hit) continue;
          case (p)
            0: l  = a;
            1: l  = l | b;
            2: rt = a;
            default: rt = rt | b;
          endcase
        end
        if (r.commas[0]) l  = l  | COMMA_FIRST;
        if (r.commas[1]) l  = l  | COMMA_SECOND;
        if (r.commas[2]) rt = rt | COMMA_FIRST;
        if (r.commas[3]) rt = rt | COMMA_SECOND;
        mirror_store[r.idx] = {l, rt};
      end
      default: mirror_store[r.idx] = '0;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("ERROR %s: got %h, expected %h at %0t ns", what, got, want, $time);
  endtask

  // Compare each accepted screen with the oldest one due
  always @(posedge clk_i) begin
    screen_t want;
    if (rst_ni === 1'b1 && scr_if.valid === 1'b1 && scr_if.ready === 1'b1) begin
      if (screens_due.size() == 0) begin
        report_mismatch("screen with none due",
                        {scr_if.left_segments, scr_if.right_segments}, '0);
      end else begin
        want = screens_due.pop_front();
        n_checked++;
        if (scr_if.left_segments !== want.left)
          report_mismatch("left_segments", 32'(scr_if.left_segments), 32'(want.left));
        if (scr_if.right_segments !== want.right)
          report_mismatch("right_segments", 32'(scr_if.right_segments),
                          32'(want.right));
        if (scr_if.shown_screen !== want.shown)
          report_mismatch("shown_screen", 32'(scr_if.shown_screen), 32'(want.shown));
      end
    end
  end

  // Output ready: random stalls, or a hold-off while pressure is applied
  always @(posedge clk_i) begin
    if (hold_out)
      scr_if.ready <= 1'b0;
    else if (sink_gaps)
      scr_if.ready <= ($urandom_range(0, 99) >= 35);
    else
      scr_if.ready <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic request_t make_req(input req_e kind, input logic [IDX_W-1:0] idx,
                                        input logic [HALF_W-1:0] lv,
                                        input logic [HALF_W-1:0] rv,
                                        input logic [31:0] txt,
                                        input logic [3:0] commas);
    request_t r;
    r.kind   = kind;
    r.idx    = idx;
    r.lv     = lv;
    r.rv     = rv;
    r.chars  = txt;
    r.commas = commas;
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] rand_char();
    int pick;
    int k;
    pick = $urandom_range(0, 99);
    k    = $urandom_range(0, FONT_N - 1);
    if (pick < 15) return '0;
    if (pick < 75) return FONT_SET[8*(FONT_N-1-k) +: 8];
    return CHAR_W'($urandom);
  endfunction

  function automatic request_t rand_request();
    request_t r;
    int       pick;
    pick = $urandom_range(0, 99);
    r.kind = (pick < 50) ? REQ_TICK : (pick < 68) ? REQ_RAW :
             (pick < 92) ? REQ_TEXT : REQ_OFF;
    r.idx  = ($urandom_range(0, 99) < 8) ? IDX_W'(3) : IDX_W'($urandom_range(0, SCREENS-1));
    r.lv   = HALF_W'($urandom);
    r.rv   = HALF_W'($urandom);
    if (r.kind == REQ_RAW && $urandom_range(0, 99) < 10) begin
      r.lv = '0;
      r.rv = '0;
    end
    for (int p = 0; p < 4; p++) r.chars[p] = rand_char();
    r.commas = 4'($urandom);
    return r;
  endfunction

  // Offer one item and wait for it to be taken
  task automatic send_request(input request_t r);
    if (src_gaps)
      while ($urandom_range(0, 99) < 35) begin
        req_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    req_if.valid        <= 1'b1;
    req_if.req_type     <= r.kind;
    req_if.screen_index <= r.idx;
    req_if.left_value   <= r.lv;
    req_if.right_value  <= r.rv;
    req_if.char_0       <= r.chars[0];
    req_if.char_1       <= r.chars[1];
    req_if.char_2       <= r.chars[2];
    req_if.char_3       <= r.chars[3];
    req_if.comma_mask   <= r.commas;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
    apply_request(r);
    n_items++;
  endtask

  // Drop valid, wait for every screen due, then let write-only work settle
  task automatic drain();
    req_if.valid <= 1'b0;
    while (screens_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Hold the write enable across back-to-back register writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DWELL_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    mirror_dwell[idx] = val;
  endtask

  task automatic set_dwells(input logic [DWELL_W-1:0] d0, input logic [DWELL_W-1:0] d1,
                            input logic [DWELL_W-1:0] d2);
    write_reg(REG_DWELL0, d0);
    write_reg(REG_DWELL1, d1);
    write_reg(REG_DWELL2, d2);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Empty store, skipping, ignored indexes, font, commas and clearing
  task automatic test_directed();
    send_request(make_req(REQ_TICK, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_RAW, 0, 16'hFFFF, 16'hFFFF, 0, 0));
    repeat (3) send_request(make_req(REQ_TICK, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_RAW, 2, 16'h0000, 16'h0001, 0, 0));
    repeat (3) send_request(make_req(REQ_TICK, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_RAW, 3, 16'h1234, 16'h5678, 0, 0));
    send_request(make_req(REQ_TEXT, 3, 0, 0, "0123", 4'hF));
    send_request(make_req(REQ_OFF, 3, 0, 0, 0, 0));
    send_request(make_req(REQ_TEXT, 1, 0, 0, "0123", 4'h0));
    repeat (2) send_request(make_req(REQ_TICK, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_TEXT, 1, 0, 0, "-AbU", 4'hF));
    // zero keeps, unknown keeps, space clears nothing when ORed
    send_request(make_req(REQ_TEXT, 1, 0, 0, {8'h00, "Z", 8'hFF, " "}, 4'b0101));
    send_request(make_req(REQ_TEXT, 2, 0, 0, "9u8o", 4'h2));
    send_request(make_req(REQ_RAW, 0, 16'h0000, 16'h0000, 0, 0));
    repeat (2) send_request(make_req(REQ_TICK, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_OFF, 1, 0, 0, 0, 0));
    send_request(make_req(REQ_OFF, 2, 0, 0, 0, 0));
    send_request(make_req(REQ_TICK, 0, 0, 0, 0, 0));
    drain();
  endtask

  // Longest and shortest dwell on filled screens
  task automatic test_dwell_extremes();
    set_dwells(8'd255, 8'd1, 8'd255);
    for (int s = 0; s < SCREENS; s++)
      send_request(make_req(REQ_RAW, IDX_W'(s), HALF_W'($urandom) | 16'h0001,
                            HALF_W'($urandom), 0, 0));
    repeat (280) send_request(make_req(REQ_TICK, 0, 0, 0, 0, 0));
    drain();
  endtask

  task automatic test_random_mix(input logic [DWELL_W-1:0] d0, input logic [DWELL_W-1:0] d1,
                                 input logic [DWELL_W-1:0] d2, input int count);
    set_dwells(d0, d1, d2);
    repeat (count) send_request(rand_request());
    drain();
  endtask

  // Back-to-back traffic on both sides
  task automatic test_no_gaps();
    src_gaps = 1'b0;
    sink_gaps <= 1'b0;
    test_random_mix(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                    8'($urandom_range(1, 255)), 130);
    src_gaps = 1'b1;
    sink_gaps <= 1'b1;
  endtask

  // Hold the output off while ticks keep coming, so the input stalls
  task automatic test_backpressure();
    set_dwells(8'd1, 8'd2, 8'd1);
    fork
      begin
        hold_out <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_out <= 1'b0;
      end
      begin
        send_request(make_req(REQ_RAW, 0, 16'hA5A5, 16'h5A5A, 0, 0));
        send_request(make_req(REQ_TEXT, 1, 0, 0, "HELP", 4'h3));
        repeat (38) send_request(make_req(REQ_TICK, 0, 0, 0, 0, 0));
      end
    join
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int waited;
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_index_i         <= REG_DWELL0;
    cfg_data_i          <= '0;
    req_if.valid        <= 1'b0;
    req_if.req_type     <= REQ_TICK;
    req_if.screen_index <= '0;
    req_if.left_value   <= '0;
    req_if.right_value  <= '0;
    req_if.char_0       <= '0;
    req_if.char_1       <= '0;
    req_if.char_2       <= '0;
    req_if.char_3       <= '0;
    req_if.comma_mask   <= '0;
    sink_gaps           <= 1'b1;
    hold_out            <= 1'b0;
    for (int s = 0; s < SCREENS; s++) mirror_store[s] = '0;
    mirror_count    = '0;
    mirror_cur      = '0;
    mirror_dwell[0] = DWELL0_RST;
    mirror_dwell[1] = DWELL1_RST;
    mirror_dwell[2] = DWELL2_RST;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_dwell_extremes();
    test_random_mix(8'd1, 8'd1, 8'd1, 130);
    test_random_mix(8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
                    8'($urandom_range(1, 4)), 150);
    test_no_gaps();
    test_backpressure();
    test_random_mix(8'd1, 8'd255, 8'd3, 100);

    // Final wait, bounded, then look for anything still due
    req_if.valid <= 1'b0;
    waited = 0;
    while (screens_due.size() != 0 && waited < END_WAIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (screens_due.size() != 0)
      report_mismatch("screens never shown", 32'(screens_due.size()), '0);

    $display("Sent %0d request items over %0d dwell settings; %0d screens checked.",
             n_items, n_settings, n_checked);
    $display("Ticks on an empty store: %0d; requests to a missing screen: %0d.",
             n_empty_ticks, n_ignored);
    if (mismatches == 0) begin
      $display("segment_display_screen_rotator_top: match");
    end else begin
      $display("segment_display_screen_rotator_top: mismatch");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #2_000_000;
    $display("segment_display_screen_rotator_top: mismatch");
    $finish;
  end

endmodule
